// ===== sv/bgi_pkg.sv =====
// Shared types and constants of the bilinear grid interpolator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bgi_pkg;

  localparam int unsigned MAX_FIRST_POINTS  = 64;
  localparam int unsigned MAX_SECOND_POINTS = 64;
  localparam int unsigned NUM_AXES          = 2;

  localparam int unsigned CELL_W     = 6;
  localparam int unsigned POINTS_W   = 7;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned WGT_W      = 32;
  localparam int unsigned PROD_W     = 2 * COORD_W;
  localparam int unsigned POS_W      = PROD_W - 16 + 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned NUM_BANKS  = 4;
  localparam int unsigned BANK_DEPTH = MAX_FIRST_POINTS * MAX_SECOND_POINTS / NUM_BANKS;
  localparam int unsigned BANK_AW    = $clog2(BANK_DEPTH);

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_ORIGIN    = 3'd0,
    CFG_SECOND_ORIGIN   = 3'd1,
    CFG_FIRST_INV_STEP  = 3'd2,
    CFG_SECOND_INV_STEP = 3'd3,
    CFG_FIRST_POINTS    = 3'd4,
    CFG_SECOND_POINTS   = 3'd5
  } cfg_idx_t;

  // A write carries its row and column in the cell fields.
  typedef struct packed {
    opcode_t                  op;
    logic [CELL_W-1:0]        cell_i;
    logic [CELL_W-1:0]        cell_j;
    logic signed [VAL_W-1:0]  value;
    logic signed [WGT_W-1:0]  wx;
    logic signed [WGT_W-1:0]  wy;
  } item_t;

endpackage

`default_nettype wire

// ===== sv/bgi_if.sv =====
// Request and result channel interfaces of the bilinear grid interpolator.
// Depends on bgi_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bgi_in_if import bgi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  opcode_t                  opcode;
  logic [CELL_W-1:0]        entry_row;
  logic [CELL_W-1:0]        entry_column;
  logic signed [VAL_W-1:0]  entry_value;
  logic [COORD_W-1:0]       query_first;
  logic [COORD_W-1:0]       query_second;

  modport source (output valid, opcode, entry_row, entry_column, entry_value,
                  query_first, query_second, input ready);
  modport sink (input valid, opcode, entry_row, entry_column, entry_value,
                query_first, query_second, output ready);
endinterface

interface bgi_out_if import bgi_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  interpolated_value;
  logic                     saturated;

  modport source (output valid, interpolated_value, saturated, input ready);
  modport sink (input valid, interpolated_value, saturated, output ready);
endinterface

`default_nettype wire

// ===== sv/bgi_front.sv =====
// Front end: configuration registers, request intake and grid location.
// Maps each query coordinate to a clamped cell and weight. Depends on bgi_pkg, bgi_if.
`timescale 1ns / 1ps
`default_nettype none

module bgi_front import bgi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bgi_in_if.sink                in_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  push,
  output item_t                 push_item,
  input  logic                  q_full
);

  localparam int unsigned AXIS_MAX [NUM_AXES] = '{MAX_FIRST_POINTS, MAX_SECOND_POINTS};
  localparam logic signed [POS_W-1:0] W_MAX = POS_W'(64'sd1073741824);
  localparam logic signed [POS_W-1:0] W_MIN = -W_MAX;

  logic [COORD_W-1:0]  org_r [NUM_AXES];
  logic [COORD_W-1:0]  inv_r [NUM_AXES];
  logic [POINTS_W-1:0] pts_r [NUM_AXES];

  logic                    v1_r, v2_r, v3_r, v4_r;
  opcode_t                 op1_r, op2_r, op3_r;
  logic [CELL_W-1:0]       row1_r, row2_r, row3_r;
  logic [CELL_W-1:0]       col1_r, col2_r, col3_r;
  logic signed [VAL_W-1:0] val1_r, val2_r, val3_r;
  logic [COORD_W-1:0]      mag1_r [NUM_AXES];
  logic                    neg1_r [NUM_AXES];
  logic                    neg2_r [NUM_AXES];
  logic [PROD_W-1:0]       prod2_r [NUM_AXES];
  logic signed [POS_W-1:0] pos3_r [NUM_AXES];
  item_t                   item4_r;

  logic                    f_en;
  logic                    accept;
  logic [COORD_W-1:0]      qin [NUM_AXES];
  logic [COORD_W-1:0]      mag_nxt [NUM_AXES];
  logic                    neg_nxt [NUM_AXES];
  logic [PROD_W-1:0]       prod_nxt [NUM_AXES];
  logic signed [POS_W-1:0] pos_nxt [NUM_AXES];
  logic [POINTS_W-1:0]     pts_eff [NUM_AXES];
  logic [CELL_W-1:0]       top [NUM_AXES];
  logic [CELL_W-1:0]       cell_nxt [NUM_AXES];
  logic signed [WGT_W-1:0] w_nxt [NUM_AXES];
  item_t                   item4_nxt;

  assign f_en          = !(v4_r && q_full);
  assign in_chan.ready = f_en;
  assign accept        = in_chan.valid && f_en;
  assign push          = v4_r && f_en;
  assign push_item     = item4_r;
  assign qin[0]        = in_chan.query_first;
  assign qin[1]        = in_chan.query_second;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      inv_r[0] <= COORD_W'(65536);
      inv_r[1] <= COORD_W'(65536);
      pts_r[0] <= POINTS_W'(AXIS_MAX[0]);
      pts_r[1] <= POINTS_W'(AXIS_MAX[1]);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FIRST_ORIGIN:    org_r[0] <= cfg_data[COORD_W-1:0];
        CFG_SECOND_ORIGIN:   org_r[1] <= cfg_data[COORD_W-1:0];
        CFG_FIRST_INV_STEP:  inv_r[0] <= cfg_data[COORD_W-1:0];
        CFG_SECOND_INV_STEP: inv_r[1] <= cfg_data[COORD_W-1:0];
        CFG_FIRST_POINTS:    pts_r[0] <= cfg_data[POINTS_W-1:0];
        CFG_SECOND_POINTS:   pts_r[1] <= cfg_data[POINTS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    logic [COORD_W:0]        diff;
    logic [PROD_W:0]         rnd;
    logic [POS_W-1:0]        mneg;
    logic [POS_W-17:0]       idx_raw;
    logic signed [POS_W-1:0] wide;
    for (int a = 0; a < NUM_AXES; a++) begin
      diff = {1'b0, qin[a]} - {1'b0, org_r[a]};
      neg_nxt[a] = diff[COORD_W];
      mag_nxt[a] = diff[COORD_W] ? (~diff[COORD_W-1:0] + COORD_W'(1)) : diff[COORD_W-1:0];

      prod_nxt[a] = PROD_W'(mag1_r[a]) * PROD_W'(inv_r[a]);

      rnd  = {1'b0, prod2_r[a]} + (PROD_W+1)'(65535);
      mneg = {1'b0, rnd[PROD_W:16]};
      pos_nxt[a] = neg2_r[a] ? -$signed(mneg) : $signed({2'b00, prod2_r[a][PROD_W-1:16]});

      if (pts_r[a] < POINTS_W'(2)) begin
        pts_eff[a] = POINTS_W'(2);
      end else if (pts_r[a] > POINTS_W'(AXIS_MAX[a])) begin
        pts_eff[a] = POINTS_W'(AXIS_MAX[a]);
      end else begin
        pts_eff[a] = pts_r[a];
      end
      top[a] = CELL_W'(pts_eff[a] - POINTS_W'(2));

      idx_raw = pos3_r[a][POS_W-1:16];
      wide    = pos3_r[a] - $signed({(POS_W-16-CELL_W)'(0), top[a], 16'h0000});
      if (pos3_r[a][POS_W-1]) begin
        cell_nxt[a] = '0;
        w_nxt[a]    = (pos3_r[a] < W_MIN) ? WGT_W'(W_MIN) : WGT_W'(pos3_r[a]);
      end else if (idx_raw > (POS_W-16)'(top[a])) begin
        cell_nxt[a] = top[a];
        w_nxt[a]    = (wide > W_MAX) ? WGT_W'(W_MAX) : WGT_W'(wide);
      end else begin
        cell_nxt[a] = idx_raw[CELL_W-1:0];
        w_nxt[a]    = $signed({16'h0000, pos3_r[a][15:0]});
      end
    end

    item4_nxt.op    = op3_r;
    item4_nxt.value = val3_r;
    item4_nxt.wx    = w_nxt[0];
    item4_nxt.wy    = w_nxt[1];
    if (op3_r == OP_QUERY) begin
      item4_nxt.cell_i = cell_nxt[0];
      item4_nxt.cell_j = cell_nxt[1];
    end else begin
      item4_nxt.cell_i = row3_r;
      item4_nxt.cell_j = col3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (f_en) begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f_en) begin
      op1_r  <= in_chan.opcode;
      row1_r <= in_chan.entry_row;
      col1_r <= in_chan.entry_column;
      val1_r <= in_chan.entry_value;
      op2_r  <= op1_r;
      row2_r <= row1_r;
      col2_r <= col1_r;
      val2_r <= val1_r;
      op3_r  <= op2_r;
      row3_r <= row2_r;
      col3_r <= col2_r;
      val3_r <= val2_r;
      for (int a = 0; a < NUM_AXES; a++) begin
        mag1_r[a]  <= mag_nxt[a];
        neg1_r[a]  <= neg_nxt[a];
        neg2_r[a]  <= neg1_r[a];
        prod2_r[a] <= prod_nxt[a];
        pos3_r[a]  <= pos_nxt[a];
      end
      item4_r <= item4_nxt;
    end
  end

  a_cell_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && item4_r.op == OP_QUERY) |-> (item4_r.cell_i <= top[0] && item4_r.cell_j <= top[1]))
    else $error("query cell lies beyond the last grid cell");

  a_weight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && item4_r.op == OP_QUERY) |->
      (item4_r.wx <= WGT_W'(W_MAX) && item4_r.wx >= WGT_W'(W_MIN) &&
       item4_r.wy <= WGT_W'(W_MAX) && item4_r.wy >= WGT_W'(W_MIN)))
    else $error("blend weight exceeds its clamp");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !f_en) |=> ($stable(v4_r) && $stable(item4_r)))
    else $error("front end lost a located request while the queue was full");

endmodule

`default_nettype wire

// ===== sv/bgi_queue.sv =====
// Short decoupling queue between front end and back end.
// Holds located requests in order. Depends on bgi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bgi_queue import bgi_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t head_item,
  output logic  empty
);

  item_t              slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty     = (count_r == '0);
  assign head_item = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bgi_back.sv =====
// Back end: four-bank value table, corner fetch and two-level bilinear blend.
// Drives the result channel from its own output register. Depends on bgi_pkg, bgi_if.
`timescale 1ns / 1ps
`default_nettype none

module bgi_back import bgi_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  item_t  head_item,
  input  logic   empty,
  output logic   pop,
  bgi_out_if.source out_chan
);

  localparam int unsigned DIFF_W = VAL_W + 1;
  localparam int unsigned MUL_W  = DIFF_W + WGT_W;
  localparam int unsigned SH_W   = MUL_W - 16;
  localparam int unsigned SUM_W  = SH_W + 1;

  function automatic logic [VAL_W:0] sat_add(logic signed [VAL_W-1:0] a,
                                             logic signed [MUL_W-1:0] p);
    logic signed [SUM_W-1:0] sum;
    sum = SUM_W'(a) + SUM_W'($signed(p[MUL_W-1:16]));
    if (sum[SUM_W-1:VAL_W-1] != {(SUM_W-VAL_W+1){sum[SUM_W-1]}}) begin
      return {1'b1, sum[SUM_W-1], {(VAL_W-1){~sum[SUM_W-1]}}};
    end
    return {1'b0, sum[VAL_W-1:0]};
  endfunction

  logic signed [VAL_W-1:0] mem [NUM_BANKS][BANK_DEPTH];
  logic signed [VAL_W-1:0] rd_r [NUM_BANKS];
  logic [BANK_AW-1:0]      rd_addr [NUM_BANKS];
  logic [BANK_AW-1:0]      wr_addr;
  logic [NUM_BANKS-1:0]    wr_en;
  logic                    b_en;

  logic                     q1_r, q2_r, q3_r, q4_r, q5_r, q6_r;
  logic                     ip1_r, jp1_r;
  logic signed [WGT_W-1:0]  wx1_r, wx2_r, wx3_r, wx4_r, wx5_r;
  logic signed [WGT_W-1:0]  wy1_r, wy2_r;
  logic signed [VAL_W-1:0]  a0_2_r, a1_2_r, a0_3_r, a1_3_r;
  logic signed [DIFF_W-1:0] d0_2_r, d1_2_r;
  logic signed [MUL_W-1:0]  p0_3_r, p1_3_r;
  logic signed [VAL_W-1:0]  v0_4_r, v1_4_r, a_5_r, a_6_r;
  logic                     clip4_r, clip5_r, clip6_r;
  logic signed [DIFF_W-1:0] d_5_r;
  logic signed [MUL_W-1:0]  p_6_r;
  logic                     out_valid_r, out_sat_r;
  logic signed [VAL_W-1:0]  out_val_r;

  logic signed [VAL_W-1:0]  c00, c01, c10, c11;
  logic [VAL_W:0]           r0_nxt, r1_nxt, r_nxt;

  assign b_en = !out_valid_r || out_chan.ready;
  assign pop  = b_en && !empty;

  assign out_chan.valid              = out_valid_r;
  assign out_chan.interpolated_value = out_val_r;
  assign out_chan.saturated          = out_sat_r;

  always_comb begin
    logic [CELL_W-1:0] rrow, rcol;
    wr_addr = {head_item.cell_i[CELL_W-1:1], head_item.cell_j[CELL_W-1:1]};
    for (int b = 0; b < NUM_BANKS; b++) begin
      rrow = (head_item.cell_i[0] == b[1]) ? head_item.cell_i
                                           : head_item.cell_i + CELL_W'(1);
      rcol = (head_item.cell_j[0] == b[0]) ? head_item.cell_j
                                           : head_item.cell_j + CELL_W'(1);
      rd_addr[b] = {rrow[CELL_W-1:1], rcol[CELL_W-1:1]};
      wr_en[b]   = pop && (head_item.op == OP_WRITE) &&
                   ({head_item.cell_i[0], head_item.cell_j[0]} == b[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        if (wr_en[b]) begin
          mem[b][wr_addr] <= head_item.value;
        end
        rd_r[b] <= mem[b][rd_addr[b]];
      end
    end
  end

  always_comb begin
    case ({ip1_r, jp1_r})
      2'b00: begin
        c00 = rd_r[0]; c01 = rd_r[1]; c10 = rd_r[2]; c11 = rd_r[3];
      end
      2'b01: begin
        c00 = rd_r[1]; c01 = rd_r[0]; c10 = rd_r[3]; c11 = rd_r[2];
      end
      2'b10: begin
        c00 = rd_r[2]; c01 = rd_r[3]; c10 = rd_r[0]; c11 = rd_r[1];
      end
      default: begin
        c00 = rd_r[3]; c01 = rd_r[2]; c10 = rd_r[1]; c11 = rd_r[0];
      end
    endcase
  end

  assign r0_nxt = sat_add(a0_3_r, p0_3_r);
  assign r1_nxt = sat_add(a1_3_r, p1_3_r);
  assign r_nxt  = sat_add(a_6_r, p_6_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_r        <= 1'b0;
      q2_r        <= 1'b0;
      q3_r        <= 1'b0;
      q4_r        <= 1'b0;
      q5_r        <= 1'b0;
      q6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (b_en) begin
      q1_r        <= pop && (head_item.op == OP_QUERY);
      q2_r        <= q1_r;
      q3_r        <= q2_r;
      q4_r        <= q3_r;
      q5_r        <= q4_r;
      q6_r        <= q5_r;
      out_valid_r <= q6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      ip1_r   <= head_item.cell_i[0];
      jp1_r   <= head_item.cell_j[0];
      wx1_r   <= head_item.wx;
      wy1_r   <= head_item.wy;

      a0_2_r  <= c00;
      a1_2_r  <= c10;
      d0_2_r  <= DIFF_W'(c01) - DIFF_W'(c00);
      d1_2_r  <= DIFF_W'(c11) - DIFF_W'(c10);
      wx2_r   <= wx1_r;
      wy2_r   <= wy1_r;

      a0_3_r  <= a0_2_r;
      a1_3_r  <= a1_2_r;
      p0_3_r  <= d0_2_r * wy2_r;
      p1_3_r  <= d1_2_r * wy2_r;
      wx3_r   <= wx2_r;

      v0_4_r  <= r0_nxt[VAL_W-1:0];
      v1_4_r  <= r1_nxt[VAL_W-1:0];
      clip4_r <= r0_nxt[VAL_W] || r1_nxt[VAL_W];
      wx4_r   <= wx3_r;

      a_5_r   <= v0_4_r;
      d_5_r   <= DIFF_W'(v1_4_r) - DIFF_W'(v0_4_r);
      clip5_r <= clip4_r;
      wx5_r   <= wx4_r;

      a_6_r   <= a_5_r;
      p_6_r   <= d_5_r * wx5_r;
      clip6_r <= clip5_r;

      out_val_r <= r_nxt[VAL_W-1:0];
      out_sat_r <= clip6_r || r_nxt[VAL_W];
    end
  end

  a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wr_en))
    else $error("more than one table bank written in a cycle");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !b_en) |=> $stable({q1_r, q2_r, q3_r, q4_r, q5_r, q6_r}))
    else $error("blend pipeline moved while the result was stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && b_en && q6_r) |=> out_chan.valid)
    else $error("finished query did not reach the result register");

endmodule

`default_nettype wire

// ===== sv/bilinear_grid_interpolator_top.sv =====
// Top level of the bilinear grid interpolator: front end, queue and back end.
// Depends on bgi_pkg, bgi_if, bgi_front, bgi_queue and bgi_back.
//
//   channel   direction  handshake          payload
//   in_chan   in         valid / ready      opcode, entry_row/column/value, query_first/second
//   out_chan  out        valid / ready      interpolated_value, saturated
//   cfg_*     in         cfg_we only        cfg_index, cfg_data
//
// One request per clock is accepted while the front end is not held by a full queue; an accepted
// query passes the front-end registers, the queue and the blend registers before out_chan.valid rises.
// Rate is set by the pipelined multipliers and the four-bank table, which reads all corners at once.
// Table writes take effect in order with later queries; unwritten table entries read undefined.
// Reset is synchronous and clears control state and loads the register defaults.
// A stalled result holds the back end; the front end keeps going until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_grid_interpolator_top import bgi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bgi_in_if.sink                in_chan,
  bgi_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic  push, q_full, pop, q_empty;
  item_t push_item, head_item;

  bgi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  bgi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head_item (head_item),
    .empty     (q_empty)
  );

  bgi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_item (head_item),
    .empty     (q_empty),
    .pop       (pop),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire
